FILE: hdl/tcpw_pkg.sv
// Shared types, codes and helpers for the text console page writer.
`timescale 1ns / 1ps

package tcpw_pkg;

   // Request kinds carried in req_tuser
   typedef enum logic [1:0] {
      FN_PUT    = 2'd0,
      FN_CLEAR  = 2'd1,
      FN_CURSOR = 2'd2,
      FN_READ   = 2'd3
   } func_type;

   // Fixed field widths of the stream ports
   localparam int FUNC_W     = 2;
   localparam int CHAR_W     = 8;
   localparam int COORD_W    = 8;
   localparam int WADDR_W    = 10;
   localparam int CODE_W     = 8;
   localparam int CCOL_W     = 6;
   localparam int CLINE_W    = 5;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;

   // Character and screen code constants
   localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [CHAR_W-1:0] PRINT_MIN    = 8'h20;
   localparam logic [CODE_W-1:0] BLANK_CODE   = 8'hA0;
   localparam logic [CODE_W-1:0] ZERO_CODE    = 8'h00;

   // One result item
   typedef struct packed {
      logic               cell_written;
      logic [WADDR_W-1:0] write_address;
      logic [CODE_W-1:0]  write_code;
      logic               scrolled;
      logic [CCOL_W-1:0]  cursor_column;
      logic [CLINE_W-1:0] cursor_line;
      logic [CODE_W-1:0]  read_code;
   } res_type;

   // Clamp a signed coordinate to 0..limit-1
   function automatic int clamp_coord(input logic signed [COORD_W-1:0] raw, input int limit);
      int v;
      v = int'(raw);
      if (v < 0) v = 0;
      if (v >= limit) v = limit - 1;
      return v;
   endfunction

endpackage

FILE: hdl/tcpw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcpw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 960
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/tcpw_char_map.sv
// Character byte to screen code mapping (case fold, normal or inverse set).
`timescale 1ns / 1ps

module tcpw_char_map (
   input  logic [tcpw_pkg::CHAR_W-1:0] char_byte,
   input  logic                        inverse_on,
   output logic [tcpw_pkg::CODE_W-1:0] code_out
);
   import tcpw_pkg::*;

   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;
   localparam logic [CHAR_W-1:0] UPPER_BASE  = 8'h40;
   localparam logic [CODE_W-1:0] HIGH_BIT    = 8'h80;
   localparam logic [CODE_W-1:0] INV_SPACE   = 8'h20;

   logic [CHAR_W-1:0] folded;

   // Fold lowercase to uppercase
   always_comb begin
      if (char_byte inside {[8'h61:8'h7A]}) begin
         folded = char_byte - CASE_OFFSET;
      end else begin
         folded = char_byte;
      end
   end

   // Normal set toggles the high bit; inverse set keeps only letters, digits, punctuation
   always_comb begin
      if (!inverse_on) begin
         code_out = folded ^ HIGH_BIT;
      end else if (folded inside {[8'h40:8'h5F]}) begin
         code_out = folded - UPPER_BASE;
      end else if (folded inside {[8'h20:8'h3F]}) begin
         code_out = folded;
      end else begin
         code_out = INV_SPACE;
      end
   end

endmodule

FILE: hdl/text_console_page_writer_top.sv
// Top level of the text console page writer: control sequencer around the page RAM.
// A COLUMNS x ROWS page of screen codes sits in one RAM with a registered read
// port; a cursor sits in flops. Put-character, set-cursor and read-cell items are
// accepted, then executed against the RAM, then wait if needed for the result
// register to drain. A put or newline that moves past the bottom row scrolls:
// rows are copied up one cell per cycle through the RAM read-to-write path and
// the bottom row is blanked. Clear fills every cell. After reset a clearing
// pass writes zero to every cell, during which no item is accepted;
// configuration writes are taken at any time. The result register lets the next
// item be accepted while a result waits.
`timescale 1ns / 1ps

module text_console_page_writer_top #(
   parameter int COLUMNS = 40,
   parameter int ROWS    = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: char_byte[7:0], col[15:8], row[23:16]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [tcpw_pkg::REQ_DATA_W-1:0]     req_tdata,
   // req_tuser: func[1:0]
   input  logic [tcpw_pkg::FUNC_W-1:0]         req_tuser,
   // rsp_tdata: write_address[9:0], write_code[17:10], scrolled[18],
   //            cursor_column[24:19], cursor_line[29:25], read_code[37:30]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tcpw_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // rsp_tuser: cell_written[0]
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [0:0]                          csr_data
);
   import tcpw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam logic [AW-1:0] SCROLL_END = AW'(CELLS - COLUMNS);
   localparam logic [AW-1:0] WALK_END   = AW'(CELLS - 1);
   localparam logic [CW-1:0] COL_LAST   = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);

   typedef enum logic [5:0] {
      ST_INIT   = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_EXEC   = 6'b000100,
      ST_SCROLL = 6'b001000,
      ST_FILL   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      inverse_ff;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;
   logic [AW-1:0] walk_ff, walk_in;

   // Captured item
   func_type                   func_ff;
   logic [CHAR_W-1:0]          char_ff;
   logic signed [COORD_W-1:0]  col_ff;
   logic signed [COORD_W-1:0]  row_ff;

   res_type res_ff, res_in;
   res_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    load_rsp;
   logic    out_free;
   logic    accept;

   // Request fields
   func_type                  req_func;
   logic [CHAR_W-1:0]         req_char;
   logic signed [COORD_W-1:0] req_col;
   logic signed [COORD_W-1:0] req_row;

   // RAM ports
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [CODE_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [CODE_W-1:0] rd_data;

   logic [CODE_W-1:0] put_code;
   logic [AW-1:0]     cur_addr;
   logic [AW-1:0]     acc_addr;

   assign req_func = func_type'(req_tuser);
   assign req_char = req_tdata[7:0];
   assign req_col  = req_tdata[15:8];
   assign req_row  = req_tdata[23:16];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;

   // Cell under the cursor and cell named by an incoming read
   assign cur_addr = AW'(int'(cur_row_ff) * COLUMNS + int'(cur_col_ff));
   assign acc_addr = AW'(clamp_coord(req_row, ROWS) * COLUMNS + clamp_coord(req_col, COLUMNS));

   tcpw_ram #(
      .WIDTH(CODE_W),
      .DEPTH(CELLS)
   ) u_page_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   tcpw_char_map u_char_map (
      .char_byte  (char_ff),
      .inverse_on (inverse_ff),
      .code_out   (put_code)
   );

   // Sequencer: execute items, walk the page for scroll, clear and init
   always_comb begin
      logic scroll_hit;
      logic clear_hit;
      scroll_hit   = 1'b0;
      clear_hit    = 1'b0;
      state_in     = state_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      walk_in      = walk_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      load_rsp     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = walk_ff;
      wr_data      = ZERO_CODE;
      rd_addr      = acc_addr;
      case (state_ff)
         ST_INIT: begin
            wr_en = 1'b1;
            if (walk_ff == WALK_END) begin
               walk_in  = '0;
               state_in = ST_IDLE;
            end else begin
               walk_in = walk_ff + AW'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in = '0;
            case (func_ff)
               FN_PUT: begin
                  if (char_ff == NEWLINE_CHAR) begin
                     cur_col_in = '0;
                     if (cur_row_ff == ROW_LAST) begin
                        scroll_hit = 1'b1;
                     end else begin
                        cur_row_in = cur_row_ff + RW'(1);
                     end
                  end else if (char_ff >= PRINT_MIN) begin
                     wr_en                = 1'b1;
                     wr_addr              = cur_addr;
                     wr_data              = put_code;
                     res_in.cell_written  = 1'b1;
                     res_in.write_address = WADDR_W'(int'(cur_addr));
                     res_in.write_code    = put_code;
                     if (cur_col_ff == COL_LAST) begin
                        cur_col_in = '0;
                        if (cur_row_ff == ROW_LAST) begin
                           scroll_hit = 1'b1;
                        end else begin
                           cur_row_in = cur_row_ff + RW'(1);
                        end
                     end else begin
                        cur_col_in = cur_col_ff + CW'(1);
                     end
                  end
               end
               FN_CLEAR: begin
                  cur_col_in = '0;
                  cur_row_in = '0;
                  clear_hit  = 1'b1;
               end
               FN_CURSOR: begin
                  cur_col_in = CW'(clamp_coord(col_ff, COLUMNS));
                  cur_row_in = RW'(clamp_coord(row_ff, ROWS));
               end
               FN_READ: begin
                  res_in.read_code = rd_data;
               end
               default: ;
            endcase
            res_in.scrolled      = scroll_hit;
            res_in.cursor_column = CCOL_W'(int'(cur_col_in));
            res_in.cursor_line   = CLINE_W'(int'(cur_row_in));
            if (scroll_hit) begin
               walk_in  = '0;
               state_in = ST_SCROLL;
            end else if (clear_hit) begin
               walk_in  = '0;
               state_in = ST_FILL;
            end else if (out_free) begin
               load_rsp = 1'b1;
               rsp_in   = res_in;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCROLL: begin
            // read one row ahead, write the data back in the following cycle
            rd_addr = AW'(int'(walk_ff) + COLUMNS);
            if (walk_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = walk_ff - AW'(1);
               wr_data = rd_data;
            end
            if (walk_ff == SCROLL_END) begin
               walk_in  = SCROLL_END;
               state_in = ST_FILL;
            end else begin
               walk_in = walk_ff + AW'(1);
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_data = BLANK_CODE;
            if (walk_ff == WALK_END) begin
               walk_in  = '0;
               state_in = ST_DONE;
            end else begin
               walk_in = walk_ff + AW'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               load_rsp = 1'b1;
               rsp_in   = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         walk_ff      <= '0;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         walk_ff      <= walk_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Inverse select register
   always_ff @(posedge clock) begin
      if (reset) begin
         inverse_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         inverse_ff <= csr_data[0];
      end
   end

   // Item capture and result registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= req_func;
         char_ff <= req_char;
         col_ff  <= req_col;
         row_ff  <= req_row;
      end
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.cell_written;
   assign rsp_tdata  = {2'b00, rsp_ff.read_code, rsp_ff.cursor_line, rsp_ff.cursor_column,
                        rsp_ff.scrolled, rsp_ff.write_code, rsp_ff.write_address};

`ifndef ASSERT_OFF
   // cursor never leaves the page
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (int'(cur_col_ff) < COLUMNS) && (int'(cur_row_ff) < ROWS))
      else $error("cursor outside page");

   // an accepted item is executed in the next cycle
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted item not executed");

   // results appear only from execute or the done hand-off
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past((state_ff == ST_EXEC) || (state_ff == ST_DONE)))
      else $error("result raised outside execute");

   // a scroll always leaves the cursor at the start of the bottom row
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.scrolled) |->
         (rsp_ff.cursor_line == CLINE_W'(ROWS - 1)) && (rsp_ff.cursor_column == '0))
      else $error("scroll with cursor off bottom row start");
`endif

endmodule
